@@ rtl/stereo_feedback_delay_top_defines.svh @@
// ---------------------------------------------------------------------------
// Stereo feedback delay assertion macros
// Concurrent assertion wrappers; compiled out when NO_ASSERTIONS is set.
// ---------------------------------------------------------------------------
`ifndef STEREO_FEEDBACK_DELAY_TOP_DEFINES_SVH
`define STEREO_FEEDBACK_DELAY_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SFD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SFD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/sfd_pkg.sv @@
// ---------------------------------------------------------------------------
// Stereo feedback delay package
// Shared constants, register indexes and types.
// ---------------------------------------------------------------------------
package sfd_pkg;

    localparam int SFD_MAX_DELAY_SAMPLES = 65536;
    localparam int SFD_SAMPLE_BITS       = 24;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int LENGTH_W    = 17;
    localparam int GAIN_W      = 16;

    typedef logic [CFG_INDEX_W-1:0] t_cfg_idx;
    typedef logic [GAIN_W-1:0]      t_gain;

    localparam t_cfg_idx REG_DELAY_LENGTH  = 3'd0;
    localparam t_cfg_idx REG_FEEDBACK_GAIN = 3'd1;
    localparam t_cfg_idx REG_DRY_GAIN      = 3'd2;
    localparam t_cfg_idx REG_WET_GAIN      = 3'd3;
    localparam t_cfg_idx REG_BYPASS_ENABLE = 3'd4;

    // Q1.15 gains
    localparam int    Q_FRAC     = 15;
    localparam t_gain UNITY_GAIN = 16'd32768;
    localparam t_gain ROUND_BIAS = 16'd16384;

    // reset values
    localparam logic [LENGTH_W-1:0] RST_DELAY_LENGTH = 17'd44100;
    localparam t_gain               RST_GAIN         = 16'd16384;

endpackage

@@ rtl/sfd_ram.sv @@
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read (old data on collision).
// ---------------------------------------------------------------------------
module sfd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/stereo_feedback_delay_top.sv @@
// ---------------------------------------------------------------------------
// Stereo feedback delay
// Feedback comb filter on a stereo stream, one delay RAM per channel.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one stereo pair plus a
//   block_end tag per transaction. Output channel (o_out_valid / i_out_stall)
//   returns one mixed pair per input transaction, in order.
//   Config channel (i_cfg_valid / o_cfg_ready) is always ready; write only
//   while the block is idle. Writing delay_length restarts the delay line.
//   Throughput: 1 transaction per cycle for delay lengths of 3 and above
//   while the receiver does not stall. For lengths 1 and 2 the RAM
//   read-modify-write loop (read, multiply, sum and write back) interlocks:
//   a transaction waits while the entry it reads is still being updated.
//   Bypass runs at 1 per cycle while the receiver does not stall.
//   Reset (synchronous, active low) loads the register defaults and starts
//   an empty delay line. No clearing pass: the RAMs are not swept; until the
//   ring position first wraps, every read is taken as zero.
//   When the receiver stalls with a result waiting, the whole pipeline
//   freezes and o_in_stall rises; no result is dropped.
// ---------------------------------------------------------------------------
`include "stereo_feedback_delay_top_defines.svh"

module stereo_feedback_delay_top #(
    parameter int MAX_DELAY_SAMPLES = sfd_pkg::SFD_MAX_DELAY_SAMPLES,
    parameter int SAMPLE_BITS       = sfd_pkg::SFD_SAMPLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]       i_right_in,
    input  logic                                i_block_end,
    // output stream
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]       o_left_out,
    output logic signed [SAMPLE_BITS-1:0]       o_right_out,
    output logic                                o_block_end_out,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  sfd_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    import sfd_pkg::*;

    // address, length and arithmetic widths
    localparam int AW      = $clog2(MAX_DELAY_SAMPLES);
    localparam int LEN_W   = $clog2(MAX_DELAY_SAMPLES + 1);
    localparam int CMP_W   = (LEN_W > LENGTH_W) ? LEN_W : LENGTH_W;
    localparam int PROD_W  = SAMPLE_BITS + GAIN_W + 1;
    localparam int ACC_W   = SAMPLE_BITS + GAIN_W + 2;
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

    // zero acts as 1, anything past the RAM depth as the depth
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LENGTH_W-1:0] len);
        logic [CMP_W-1:0] v;
        v = CMP_W'(len);
        if (v == '0) begin
            return LEN_W'(1);
        end else if (v > CMP_W'(MAX_DELAY_SAMPLES)) begin
            return LEN_W'(MAX_DELAY_SAMPLES);
        end
        return LEN_W'(v);
    endfunction

    function automatic t_gain clamp_gain(input t_gain g);
        return (g > UNITY_GAIN) ? UNITY_GAIN : g;
    endfunction

    // round half up by 2^15, then saturate to the sample width
    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] q;
        t = v + $signed(ACC_W'(ROUND_BIAS));
        q = t >>> Q_FRAC;
        if (q > SAT_MAX) begin
            return SAMPLE_BITS'(SAT_MAX);
        end else if (q < SAT_MIN) begin
            return SAMPLE_BITS'(SAT_MIN);
        end
        return SAMPLE_BITS'(q);
    endfunction

    // ---------------- configuration registers ----------------
    logic [LEN_W-1:0] r_active_len;
    t_gain            r_fb_gain;
    t_gain            r_dry_gain;
    t_gain            r_wet_gain;
    logic             r_bypass;
    logic             w_cfg_we;
    logic             w_len_we;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid;
    assign w_len_we    = w_cfg_we && (i_cfg_index == REG_DELAY_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_len <= clamp_len(RST_DELAY_LENGTH);
            r_fb_gain    <= RST_GAIN;
            r_dry_gain   <= RST_GAIN;
            r_wet_gain   <= RST_GAIN;
            r_bypass     <= 1'b0;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                REG_DELAY_LENGTH:  r_active_len <= clamp_len(i_cfg_data[LENGTH_W-1:0]);
                REG_FEEDBACK_GAIN: r_fb_gain    <= clamp_gain(i_cfg_data[GAIN_W-1:0]);
                REG_DRY_GAIN:      r_dry_gain   <= clamp_gain(i_cfg_data[GAIN_W-1:0]);
                REG_WET_GAIN:      r_wet_gain   <= clamp_gain(i_cfg_data[GAIN_W-1:0]);
                REG_BYPASS_ENABLE: r_bypass     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // Stage 0: accept, issue RAM read at the ring position.
    // Stage 1: RAM data back, form the three products per channel.
    // Stage 2: sum, round, saturate; write back and load the output register.
    logic          r_s1_valid, r_s2_valid, r_out_valid;
    logic          r_s1_byp, r_s2_byp;
    logic          r_s1_dv;
    logic [AW-1:0] r_s1_pos, r_s2_pos;
    logic [AW-1:0] r_pos;
    logic          r_wrapped;   // ring has wrapped since the last restart
    logic          w_en;
    logic          w_hazard;
    logic          w_accept;
    logic          w_ring_acc;
    logic [LEN_W-1:0] w_pos_inc;

    // pipeline moves when the output register is empty or being taken
    assign w_en = !r_out_valid || !i_out_stall;

    // an entry still being updated in stage 1 or 2 must not be read again
    assign w_hazard = !r_bypass &&
                      ((r_s1_valid && !r_s1_byp && (r_s1_pos == r_pos)) ||
                       (r_s2_valid && !r_s2_byp && (r_s2_pos == r_pos)));

    assign o_in_stall = !w_en || w_hazard;
    assign w_accept   = i_in_valid && w_en && !w_hazard;
    assign w_ring_acc = w_accept && !r_bypass;
    assign w_pos_inc  = LEN_W'(r_pos) + LEN_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_wrapped   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_len_we) begin
                // new length: start an empty ring at position zero
                r_pos     <= '0;
                r_wrapped <= 1'b0;
            end else if (w_ring_acc) begin
                if (w_pos_inc >= r_active_len) begin
                    r_pos     <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_pos <= AW'(w_pos_inc);
                end
            end
            if (w_en) begin
                r_s1_valid  <= w_accept;
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // ---------------- delay RAMs ----------------
    logic                          w_ram_we;
    logic signed [SAMPLE_BITS-1:0] w_wr_l, w_wr_r;
    logic        [SAMPLE_BITS-1:0] w_rd_l, w_rd_r;

    assign w_ram_we = w_en && r_s2_valid && !r_s2_byp;

    sfd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_DELAY_SAMPLES)
    ) u_ram_left (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_s2_pos),
        .i_wdata (w_wr_l),
        .i_re    (w_ring_acc),
        .i_raddr (r_pos),
        .o_rdata (w_rd_l)
    );

    sfd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_DELAY_SAMPLES)
    ) u_ram_right (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_s2_pos),
        .i_wdata (w_wr_r),
        .i_re    (w_ring_acc),
        .i_raddr (r_pos),
        .o_rdata (w_rd_r)
    );

    // ---------------- stage 1 ----------------
    logic signed [SAMPLE_BITS-1:0] r_s1_xl, r_s1_xr;
    logic                          r_s1_be;
    logic signed [SAMPLE_BITS-1:0] w_dl, w_dr;
    logic signed [PROD_W-1:0]      w_pdl, w_pwl, w_pfl, w_pdr, w_pwr, w_pfr;

    always_ff @(posedge i_clk) begin
        if (w_en && w_accept) begin
            r_s1_xl  <= i_left_in;
            r_s1_xr  <= i_right_in;
            r_s1_be  <= i_block_end;
            r_s1_byp <= r_bypass;
            r_s1_pos <= r_pos;
            r_s1_dv  <= r_wrapped;
        end
    end

    // entries not yet written since the restart read as zero
    assign w_dl = r_s1_dv ? $signed(w_rd_l) : '0;
    assign w_dr = r_s1_dv ? $signed(w_rd_r) : '0;

    assign w_pdl = r_s1_xl * $signed({1'b0, r_dry_gain});
    assign w_pwl = w_dl    * $signed({1'b0, r_wet_gain});
    assign w_pfl = w_dl    * $signed({1'b0, r_fb_gain});
    assign w_pdr = r_s1_xr * $signed({1'b0, r_dry_gain});
    assign w_pwr = w_dr    * $signed({1'b0, r_wet_gain});
    assign w_pfr = w_dr    * $signed({1'b0, r_fb_gain});

    // ---------------- stage 2 ----------------
    logic signed [SAMPLE_BITS-1:0] r_s2_xl, r_s2_xr;
    logic                          r_s2_be;
    logic signed [PROD_W-1:0]      r_pdl, r_pwl, r_pfl, r_pdr, r_pwr, r_pfr;
    logic signed [ACC_W-1:0]       w_mix_l, w_mix_r, w_fb_l, w_fb_r;
    logic signed [SAMPLE_BITS-1:0] w_y_l, w_y_r;

    always_ff @(posedge i_clk) begin
        if (w_en && r_s1_valid) begin
            r_s2_xl  <= r_s1_xl;
            r_s2_xr  <= r_s1_xr;
            r_s2_be  <= r_s1_be;
            r_s2_byp <= r_s1_byp;
            r_s2_pos <= r_s1_pos;
            r_pdl    <= w_pdl;
            r_pwl    <= w_pwl;
            r_pfl    <= w_pfl;
            r_pdr    <= w_pdr;
            r_pwr    <= w_pwr;
            r_pfr    <= w_pfr;
        end
    end

    assign w_mix_l = ACC_W'(r_pdl) + ACC_W'(r_pwl);
    assign w_mix_r = ACC_W'(r_pdr) + ACC_W'(r_pwr);
    assign w_fb_l  = (ACC_W'(r_s2_xl) <<< Q_FRAC) + ACC_W'(r_pfl);
    assign w_fb_r  = (ACC_W'(r_s2_xr) <<< Q_FRAC) + ACC_W'(r_pfr);

    assign w_y_l  = round_sat(w_mix_l);
    assign w_y_r  = round_sat(w_mix_r);
    assign w_wr_l = round_sat(w_fb_l);
    assign w_wr_r = round_sat(w_fb_r);

    // ---------------- output register ----------------
    logic signed [SAMPLE_BITS-1:0] r_out_l, r_out_r;
    logic                          r_out_be;

    always_ff @(posedge i_clk) begin
        if (w_en && r_s2_valid) begin
            r_out_l  <= r_s2_byp ? r_s2_xl : w_y_l;
            r_out_r  <= r_s2_byp ? r_s2_xr : w_y_r;
            r_out_be <= r_s2_be;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_left_out      = r_out_l;
    assign o_right_out     = r_out_r;
    assign o_block_end_out = r_out_be;

    // ---------------- assertions ----------------
    // never read an entry in the same cycle it is written back
    `SFD_ASSERT_IMP(a_no_rw_collision, i_clk, i_rst_n, w_ram_we && w_ring_acc, r_s2_pos != r_pos)
    // ring position stays inside the active length
    `SFD_ASSERT_IMP(a_pos_in_range, i_clk, i_rst_n, 1'b1, LEN_W'(r_pos) < r_active_len)
    // length write restarts the ring
    `SFD_ASSERT_NXT(a_len_restart, i_clk, i_rst_n, w_len_we, (r_pos == '0) && !r_wrapped)
    // bypassed samples leave the ring position alone
    `SFD_ASSERT_NXT(a_bypass_hold, i_clk, i_rst_n, w_accept && r_bypass && !w_cfg_we, $stable(r_pos))

endmodule

@@ verif/sfd_checker.sv @@
// ----------------------------------------------------------------------------
// Stereo feedback delay checker
// Tracks config writes and input transactions and predicts each mixed pair.
// It compares every output transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module sfd_checker (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_in_valid,
    input  logic                                       i_in_stall,
    input  logic signed [sfd_pkg::SFD_SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [sfd_pkg::SFD_SAMPLE_BITS-1:0] i_right_in,
    input  logic                                       i_block_end,
    input  logic                                       i_out_valid,
    input  logic                                       i_out_stall,
    input  logic signed [sfd_pkg::SFD_SAMPLE_BITS-1:0] i_left_out,
    input  logic signed [sfd_pkg::SFD_SAMPLE_BITS-1:0] i_right_out,
    input  logic                                       i_block_end_out,
    input  logic                                       i_cfg_valid,
    input  logic                                       i_cfg_ready,
    input  sfd_pkg::t_cfg_idx                          i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]             i_cfg_data,
    output int                                         o_fail_count,
    output int                                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import sfd_pkg::*;

    localparam int SB        = SFD_SAMPLE_BITS;
    localparam int PRINT_CAP = 100;

    typedef logic signed [SB-1:0] t_sample;

    typedef struct packed {
        t_sample left_smp;
        t_sample right_smp;
        logic    blk_end;
    } t_mix;

    t_sample     left_ring  [SFD_MAX_DELAY_SAMPLES];
    t_sample     right_ring [SFD_MAX_DELAY_SAMPLES];
    int unsigned ring_pos;
    int unsigned ring_len;
    t_gain       fb_gain;
    t_gain       dry_gain;
    t_gain       wet_gain;
    logic        bypass;
    t_mix        expected_mix_q [$];
    int          fails = 0;

    assign o_fail_count = fails;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fails < PRINT_CAP)
            $display("[%0t] sfd_checker: %s: got %0d, want %0d", $time, what, got, want);
        fails++;
    endtask

    function automatic longint sat_sample(input longint v);
        longint hi = (longint'(1) <<< (SB - 1)) - 1;
        longint lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // round half up on Q15 products
    function automatic longint q15_round(input longint v);
        return (v + longint'(ROUND_BIAS)) >>> Q_FRAC;
    endfunction

    function automatic t_gain clamp_gain(input logic [CFG_DATA_W-1:0] v);
        t_gain g = v[GAIN_W-1:0];
        return (g > UNITY_GAIN) ? UNITY_GAIN : g;
    endfunction

    function automatic void restart_ring(input logic [LENGTH_W-1:0] len);
        for (int i = 0; i < SFD_MAX_DELAY_SAMPLES; i++) begin
            left_ring[i]  = '0;
            right_ring[i] = '0;
        end
        ring_pos = 0;
        if (len == 0)
            ring_len = 1;
        else if (len > SFD_MAX_DELAY_SAMPLES)
            ring_len = SFD_MAX_DELAY_SAMPLES;
        else
            ring_len = len;
    endfunction

    // one comb tap: mixed output and the value fed back into the ring
    function automatic void comb_tap(input t_sample x, input t_sample d,
                                     output t_sample y, output t_sample w);
        longint xs = x;
        longint ds = d;
        y = t_sample'(sat_sample(q15_round(longint'(dry_gain) * xs + longint'(wet_gain) * ds)));
        w = t_sample'(sat_sample(q15_round(xs * longint'(UNITY_GAIN) + longint'(fb_gain) * ds)));
    endfunction

    function automatic t_mix predict_mix(input t_sample xl, input t_sample xr, input logic be);
        t_mix        r;
        t_sample     wl;
        t_sample     wr;
        int unsigned p;
        r.blk_end = be;
        if (bypass) begin
            r.left_smp  = xl;
            r.right_smp = xr;
        end else begin
            p = (ring_pos >= ring_len) ? 0 : ring_pos;
            comb_tap(xl, left_ring[p], r.left_smp, wl);
            comb_tap(xr, right_ring[p], r.right_smp, wr);
            left_ring[p]  = wl;
            right_ring[p] = wr;
            p++;
            if (p >= ring_len) p = 0;
            ring_pos = p;
        end
        return r;
    endfunction

    function automatic void apply_cfg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_DELAY_LENGTH:  restart_ring(data[LENGTH_W-1:0]);
            REG_FEEDBACK_GAIN: fb_gain  = clamp_gain(data);
            REG_DRY_GAIN:      dry_gain = clamp_gain(data);
            REG_WET_GAIN:      wet_gain = clamp_gain(data);
            REG_BYPASS_ENABLE: bypass   = data[0];
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_mix want;
        if (!i_rst_n) begin
            fb_gain  = RST_GAIN;
            dry_gain = RST_GAIN;
            wet_gain = RST_GAIN;
            bypass   = 1'b0;
            restart_ring(RST_DELAY_LENGTH);
            expected_mix_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                apply_cfg(i_cfg_index, i_cfg_data);
            // outputs first: a result can never belong to this edge's input
            if (i_out_valid && !i_out_stall) begin
                if (expected_mix_q.size() == 0) begin
                    report_mismatch("output with no transaction pending", i_left_out, 0);
                end else begin
                    want = expected_mix_q.pop_front();
                    if (i_left_out !== want.left_smp)
                        report_mismatch("left_out", i_left_out, want.left_smp);
                    if (i_right_out !== want.right_smp)
                        report_mismatch("right_out", i_right_out, want.right_smp);
                    if (i_block_end_out !== want.blk_end)
                        report_mismatch("block_end_out", i_block_end_out, want.blk_end);
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_mix_q.push_back(predict_mix(i_left_in, i_right_in, i_block_end));
        end
        o_pending <= expected_mix_q.size();
    end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// Stereo feedback delay testbench
// Directed corner transactions, then random config phases and samples under
// three idle/stall regimes; a checker beside the DUT predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfd_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RST_CYCLES   = 4;
    localparam int RANDOM_ITEMS = 1930;
    localparam int TAIL_CYCLES  = 8;      // settling time after the last drain
    localparam int TIMEOUT_NS   = 5000000;

    localparam int SB = SFD_SAMPLE_BITS;
    typedef logic signed [SB-1:0] t_sample;

    localparam t_sample SMP_MAX   = {1'b0, {(SB-1){1'b1}}};
    localparam t_sample SMP_MIN   = {1'b1, {(SB-1){1'b0}}};
    localparam t_sample SMP_ALT_A = {(SB/2){2'b01}};
    localparam t_sample SMP_ALT_B = {(SB/2){2'b10}};

    // indexes past the last register; writes there must be ignored
    localparam t_cfg_idx REG_NONE_LO = REG_BYPASS_ENABLE + 3'd1;
    localparam t_cfg_idx REG_NONE_HI = {CFG_INDEX_W{1'b1}};

    localparam int unsigned LEN_FIELD_MAX = (1 << LENGTH_W) - 1;
    localparam int unsigned GAIN_FIELD_MAX = (1 << GAIN_W) - 1;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    t_sample               left_in       = '0;
    t_sample               right_in      = '0;
    logic                  block_end     = 1'b0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    t_sample               left_out;
    t_sample               right_out;
    logic                  block_end_out;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    t_cfg_idx              cfg_index     = REG_DELAY_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    int fail_count;
    int pending;
    int src_idle_pct  = 16;   // sender idles in this many cycles of 100
    int snk_stall_pct = 61;   // receiver stalls in this many cycles of 100
    int sent_random   = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    stereo_feedback_delay_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_left_in       (left_in),
        .i_right_in      (right_in),
        .i_block_end     (block_end),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_left_out      (left_out),
        .o_right_out     (right_out),
        .o_block_end_out (block_end_out),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    sfd_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_left_in       (left_in),
        .i_right_in      (right_in),
        .i_block_end     (block_end),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_left_out      (left_out),
        .i_right_out     (right_out),
        .i_block_end_out (block_end_out),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Receiver back-pressure: an independent coin per cycle. With the
    // percentage at zero the output side never stalls.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < snk_stall_pct);

    // One input transaction. Idle cycles come first (valid low), then valid
    // is held with a steady payload until the edge where stall is low.
    // Valid is only ever changed once per time step.
    task automatic send_sample(input t_sample l, input t_sample r, input logic be);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        left_in   <= l;
        right_in  <= r;
        block_end <= be;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid and wait until the checker has seen every result come back.
    // The pending count is registered, so the task waits on the clock before checking.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // One config transaction; valid stays up so back-to-back writes never
    // lower and raise it in the same step. Caller drops it after the group.
    task automatic write_reg(input t_cfg_idx idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Gains, bypass, optional length. Only called with the pipeline drained.
    task automatic set_regs(input bit wr_len, input int unsigned len, input int unsigned fb,
                            input int unsigned dry, input int unsigned wet, input bit byp,
                            input bit wr_junk);
        if (wr_junk)
            write_reg(t_cfg_idx'($urandom_range(REG_NONE_HI, REG_NONE_LO)), $urandom);
        if (wr_len)
            write_reg(REG_DELAY_LENGTH, len);
        write_reg(REG_FEEDBACK_GAIN, fb);
        write_reg(REG_DRY_GAIN, dry);
        write_reg(REG_WET_GAIN, wet);
        write_reg(REG_BYPASS_ENABLE, byp);
        cfg_valid <= 1'b0;
    endtask

    // Mix of rails, small, mid-size and full-range samples; full-range
    // draws toggle every bit, small ones keep the mix out of saturation.
    function automatic t_sample random_sample();
        case ($urandom_range(9))
            0:       return SMP_MAX;
            1:       return SMP_MIN;
            2, 3:    return t_sample'(int'($urandom_range(2047)) - 1024);
            4, 5:    return t_sample'(int'($urandom_range(1 << 20)) - (1 << 19));
            default: return t_sample'($urandom);
        endcase
    endfunction

    function automatic int unsigned random_gain();
        case ($urandom_range(7))
            0:       return 0;
            1:       return UNITY_GAIN;
            2:       return GAIN_FIELD_MAX;             // clamps to unity
            3:       return $urandom_range(GAIN_FIELD_MAX);
            default: return $urandom_range(UNITY_GAIN);
        endcase
    endfunction

    // Short rings dominate so the feedback path wraps many times; the
    // zero, maximum and over-range lengths show up now and then.
    function automatic int unsigned random_length();
        case ($urandom_range(19))
            0:       return 0;
            1:       return SFD_MAX_DELAY_SAMPLES;
            2:       return $urandom_range(LEN_FIELD_MAX, SFD_MAX_DELAY_SAMPLES + 1);
            3:       return RST_DELAY_LENGTH;
            4, 5, 6: return $urandom_range(300, 9);
            default: return $urandom_range(8, 1);
        endcase
    endfunction

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #(TIMEOUT_NS);
        $display("tb failed");
        $finish;
    end

    initial begin
        int n;

        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: register defaults after reset (long ring, reads 0)
        send_sample(SMP_MAX, SMP_MAX, 1'b0);
        send_sample(SMP_MIN, SMP_MIN, 1'b0);
        send_sample('0, '0, 1'b0);
        send_sample(SMP_MAX, SMP_MIN, 1'b1);
        send_sample(SMP_ALT_A, SMP_ALT_B, 1'b0);
        send_sample(SMP_ALT_B, SMP_ALT_A, 1'b1);

        // ---- length 1, all gains at unity: feedback and mix both saturate
        wait_idle();
        set_regs(1'b1, 1, UNITY_GAIN, UNITY_GAIN, UNITY_GAIN, 1'b0, 1'b0);
        repeat (3) send_sample(SMP_MAX, SMP_MAX, 1'b0);
        repeat (3) send_sample(SMP_MIN, SMP_MIN, 1'b1);

        // ---- zero length acts as one; gains above unity clamp
        wait_idle();
        set_regs(1'b1, 0, GAIN_FIELD_MAX, 0, GAIN_FIELD_MAX, 1'b0, 1'b0);
        send_sample(t_sample'(1), t_sample'(-1), 1'b0);
        send_sample(t_sample'(-1), t_sample'(1), 1'b1);
        send_sample(SMP_MIN, SMP_MAX, 1'b0);

        // ---- writes to unused indexes are dropped; length 2, zero gains
        wait_idle();
        write_reg(REG_NONE_LO, LEN_FIELD_MAX);
        write_reg(REG_NONE_HI, LEN_FIELD_MAX);
        set_regs(1'b1, 2, 0, 0, 0, 1'b0, 1'b0);
        send_sample(SMP_MAX, SMP_MIN, 1'b0);
        send_sample(SMP_ALT_A, SMP_ALT_B, 1'b0);
        send_sample(SMP_MIN, SMP_MAX, 1'b1);

        // ---- bypass with an over-range length (acts as the maximum)
        wait_idle();
        set_regs(1'b1, LEN_FIELD_MAX, UNITY_GAIN, RST_GAIN, RST_GAIN, 1'b1, 1'b0);
        send_sample(SMP_MAX, SMP_MIN, 1'b1);
        send_sample(SMP_ALT_B, SMP_ALT_A, 1'b0);
        send_sample(SMP_MIN, SMP_MAX, 1'b0);

        // ---- same length written again still restarts the ring
        wait_idle();
        set_regs(1'b1, LEN_FIELD_MAX, UNITY_GAIN, RST_GAIN, RST_GAIN, 1'b0, 1'b0);
        send_sample(SMP_MAX, SMP_MAX, 1'b0);
        send_sample(SMP_MIN, SMP_MIN, 1'b1);

        // ---- random phases: new settings each phase, random samples.
        // Regime: sender 16 / receiver 61, then swapped, then no idling.
        while (sent_random < RANDOM_ITEMS) begin
            if (sent_random >= (2 * RANDOM_ITEMS) / 3) begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end else if (sent_random >= RANDOM_ITEMS / 3) begin
                src_idle_pct  = 61;
                snk_stall_pct = 16;
            end
            wait_idle();
            // keeping the old length now and then lets ring contents carry
            // across a gain change
            set_regs($urandom_range(3) != 0, random_length(), random_gain(),
                     random_gain(), random_gain(), $urandom_range(5) == 0,
                     $urandom_range(7) == 0);
            n = $urandom_range(160, 40);
            if (n > RANDOM_ITEMS - sent_random)
                n = RANDOM_ITEMS - sent_random;
            repeat (n) begin
                send_sample(random_sample(), random_sample(), 1'($urandom_range(1)));
                sent_random++;
                // occasional full drain mid-phase
                if ($urandom_range(63) == 0)
                    wait_idle();
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sfd_pkg.sv
rtl/sfd_ram.sv
rtl/stereo_feedback_delay_top.sv
verif/sfd_checker.sv
verif/tb.sv
